// ----- rtl/tsdf_pkg.sv -----
`default_nettype none
package tsdf_pkg;

  localparam int PIXEL_COORD_BITS = 8;
  localparam int FRAC_BITS        = 8;
  localparam int STROKE_BITS      = 12;
  localparam int CHAN_BITS        = 8;
  localparam int CFG_INDEX_BITS   = 3;
  localparam int CFG_DATA_BITS    = 48;
  localparam logic [STROKE_BITS-1:0] STROKE_RESET = 12'd256;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_TRI_AX      = 3'd0,
    REG_TRI_AY      = 3'd1,
    REG_TRI_BX      = 3'd2,
    REG_TRI_BY      = 3'd3,
    REG_TRI_CX      = 3'd4,
    REG_TRI_CY      = 3'd5,
    REG_STROKE_HALF = 3'd6,
    REG_COLOUR_PAIR = 3'd7
  } reg_index_t;

  typedef struct packed {
    logic [PIXEL_COORD_BITS-1:0] pixel_x;
    logic [PIXEL_COORD_BITS-1:0] pixel_y;
  } pixel_t;

  typedef struct packed {
    logic [31:0] pixel_argb;
    logic        covered;
  } result_t;

endpackage
`default_nettype wire

// ----- rtl/triangle_sdf_stroke_rasteriser_top.sv -----
`default_nettype none
// Antialiased outlined triangle rasteriser. Each pixel word (column, row) gives one
// premultiplied ARGB word for the configured triangle, stroke half-width and outline and
// inlay colours. One pixel enters per clock unless the output stalls. Distances come from
// the one-bit-per-stage square root and the one-bit-per-stage distance divider. A stall
// at the output holds the whole pipeline.
// Write configuration only while the pipeline is empty.
module triangle_sdf_stroke_rasteriser_top #(
  parameter int FRAC_BITS = tsdf_pkg::FRAC_BITS
) (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire                                  pixel_valid,
  output logic                                 pixel_ready,
  input  tsdf_pkg::pixel_t                     pixel,
  output logic                                 result_valid,
  input  wire                                  result_ready,
  output tsdf_pkg::result_t                    result,
  input  wire                                  cfg_we,
  input  wire  [tsdf_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  wire  [tsdf_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

  localparam int P   = tsdf_pkg::PIXEL_COORD_BITS;
  localparam int F   = FRAC_BITS;
  localparam int C   = P + F;
  localparam int E   = C + 1;
  localparam int PW  = 2 * E;
  localparam int SQ  = 2 * C + 1;
  localparam int R   = C + 1;
  localparam int NQ  = 2 * C + 1;
  localparam int DW  = NQ + 1;
  localparam int KW  = DW + 2;
  localparam int SB  = tsdf_pkg::STROKE_BITS;
  localparam int CB  = tsdf_pkg::CHAN_BITS;
  localparam int PRW = CB + 1 + F + 1;
  localparam int NW  = PRW + 1;
  localparam int MW  = NW + F + 2;
  localparam int AW  = F + 9;
  localparam logic signed [KW-1:0] HALF_K = KW'(1) <<< (F - 1);
  localparam logic signed [KW-1:0] ONE_K  = KW'(1) <<< F;
  localparam logic [MW-1:0] ROUND_M = MW'(1) << (2 * F - 1);
  localparam logic [AW-1:0] ROUND_A = AW'(1) << (F - 1);

  typedef struct packed {
    logic [R+1:0]   rem;
    logic [R-1:0]   root;
    logic [2*R-1:0] rad;
    logic           interior;
    logic [SQ-1:0]  mag;
  } sq_t;

  typedef struct packed {
    logic [R-1:0]  rem;
    logic [R-1:0]  root;
    logic [NQ-1:0] q;
    logic          interior;
  } dv_t;

  function automatic sq_t sq_step(sq_t s);
    sq_t o;
    logic [R+1:0] rem2;
    logic [R+1:0] trial;
    logic ge;
    o = s;
    rem2 = {s.rem[R-1:0], s.rad[2*R-1:2*R-2]};
    trial = {s.root, 2'b01};
    ge = rem2 >= trial;
    o.rem = ge ? rem2 - trial : rem2;
    o.root = {s.root[R-2:0], ge};
    o.rad = {s.rad[2*R-3:0], 2'b00};
    return o;
  endfunction

  function automatic dv_t dv_step(dv_t s);
    dv_t o;
    logic [R:0] rem2;
    logic ge;
    o = s;
    rem2 = {s.rem, s.q[NQ-1]};
    ge = rem2 >= {1'b0, s.root};
    o.rem = ge ? R'(rem2 - {1'b0, s.root}) : rem2[R-1:0];
    o.q = {s.q[NQ-2:0], ge};
    return o;
  endfunction

  function automatic logic [F:0] clamp_unit(logic signed [KW-1:0] v);
    logic [F:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > ONE_K) begin
      r = ONE_K[F:0];
    end else begin
      r = v[F:0];
    end
    return r;
  endfunction

  // configuration
  logic [C-1:0]  vtx_x [3];
  logic [C-1:0]  vtx_y [3];
  logic [SB-1:0] stroke_hw;
  logic [tsdf_pkg::CFG_DATA_BITS-1:0] colour_pair;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        vtx_x[i] <= '0;
        vtx_y[i] <= '0;
      end
      stroke_hw <= tsdf_pkg::STROKE_RESET;
      colour_pair <= '0;
    end else if (cfg_we) begin
      case (tsdf_pkg::reg_index_t'(cfg_index))
        tsdf_pkg::REG_TRI_AX:      vtx_x[0] <= cfg_data[C-1:0];
        tsdf_pkg::REG_TRI_AY:      vtx_y[0] <= cfg_data[C-1:0];
        tsdf_pkg::REG_TRI_BX:      vtx_x[1] <= cfg_data[C-1:0];
        tsdf_pkg::REG_TRI_BY:      vtx_y[1] <= cfg_data[C-1:0];
        tsdf_pkg::REG_TRI_CX:      vtx_x[2] <= cfg_data[C-1:0];
        tsdf_pkg::REG_TRI_CY:      vtx_y[2] <= cfg_data[C-1:0];
        tsdf_pkg::REG_STROKE_HALF: stroke_hw <= cfg_data[SB-1:0];
        tsdf_pkg::REG_COLOUR_PAIR: colour_pair <= cfg_data;
        default: ;
      endcase
    end
  end

  logic signed [E-1:0] ex [3];
  logic signed [E-1:0] ey [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ex[i] = $signed({1'b0, vtx_x[(i == 2) ? 0 : i + 1]}) - $signed({1'b0, vtx_x[i]});
      ey[i] = $signed({1'b0, vtx_y[(i == 2) ? 0 : i + 1]}) - $signed({1'b0, vtx_y[i]});
    end
  end

  logic en;
  assign en = !result_valid || result_ready;
  assign pixel_ready = en;

  // stage A: point relative to vertices
  logic                vld_a;
  logic signed [E-1:0] va_x [3];
  logic signed [E-1:0] va_y [3];
  logic [C-1:0]        px;
  logic [C-1:0]        py;

  assign px = {pixel.pixel_x, 1'b1, {(F-1){1'b0}}};
  assign py = {pixel.pixel_y, 1'b1, {(F-1){1'b0}}};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_a <= 1'b0;
    end else if (en) begin
      vld_a <= pixel_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        va_x[i] <= $signed({1'b0, px}) - $signed({1'b0, vtx_x[i]});
        va_y[i] <= $signed({1'b0, py}) - $signed({1'b0, vtx_y[i]});
      end
    end
  end

  // stage B: products
  logic                 vld_b;
  logic signed [PW-1:0] pb_vex [3];
  logic signed [PW-1:0] pb_vey [3];
  logic signed [PW-1:0] pb_vxx [3];
  logic signed [PW-1:0] pb_vyy [3];
  logic signed [PW-1:0] pb_exx [3];
  logic signed [PW-1:0] pb_eyy [3];
  logic signed [PW-1:0] pb_vxey [3];
  logic signed [PW-1:0] pb_vyex [3];
  logic signed [PW-1:0] pb_w0;
  logic signed [PW-1:0] pb_w1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_b <= 1'b0;
    end else if (en) begin
      vld_b <= vld_a;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        pb_vex[i]  <= va_x[i] * ex[i];
        pb_vey[i]  <= va_y[i] * ey[i];
        pb_vxx[i]  <= va_x[i] * va_x[i];
        pb_vyy[i]  <= va_y[i] * va_y[i];
        pb_exx[i]  <= ex[i] * ex[i];
        pb_eyy[i]  <= ey[i] * ey[i];
        pb_vxey[i] <= va_x[i] * ey[i];
        pb_vyex[i] <= va_y[i] * ex[i];
      end
      pb_w0 <= ex[0] * ey[2];
      pb_w1 <= ey[0] * ex[2];
    end
  end

  // stage C: sums
  logic                 vld_c;
  logic signed [PW-1:0] cc_dot [3];
  logic [SQ-1:0]        cc_vsq [3];
  logic [SQ-1:0]        cc_len [3];
  logic signed [PW-1:0] cc_cr [3];
  logic signed [PW-1:0] cc_wind;
  logic signed [PW-1:0] vsq_sum [3];
  logic signed [PW-1:0] len_sum [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      vsq_sum[i] = pb_vxx[i] + pb_vyy[i];
      len_sum[i] = pb_exx[i] + pb_eyy[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_c <= 1'b0;
    end else if (en) begin
      vld_c <= vld_b;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        cc_dot[i] <= pb_vex[i] + pb_vey[i];
        cc_vsq[i] <= vsq_sum[i][SQ-1:0];
        cc_len[i] <= len_sum[i][SQ-1:0];
        cc_cr[i]  <= pb_vxey[i] - pb_vyex[i];
      end
      cc_wind <= pb_w0 - pb_w1;
    end
  end

  // square root pipeline, one root bit per stage
  sq_t  sq [R+1][3];
  logic sq_vld [R+1];
  logic sq_inside [R+1];
  sq_t  sq_load [3];
  logic inside_load;

  always_comb begin
    logic endpoint;
    logic far;
    logic all_pos;
    logic signed [PW-1:0] cp;
    logic [SQ-1:0] rad;
    all_pos = 1'b1;
    for (int i = 0; i < 3; i++) begin
      endpoint = (cc_len[i] == '0) || (cc_dot[i] <= 0);
      far = !endpoint && (cc_dot[i] >= $signed({1'b0, cc_len[i]}));
      rad = endpoint ? cc_vsq[i] : (far ? cc_vsq[(i == 2) ? 0 : i + 1] : cc_len[i]);
      sq_load[i].rem = '0;
      sq_load[i].root = '0;
      sq_load[i].rad = {1'b0, rad};
      sq_load[i].interior = !endpoint && !far;
      sq_load[i].mag = cc_cr[i] < 0 ? SQ'(-cc_cr[i]) : cc_cr[i][SQ-1:0];
      cp = (cc_wind < 0) ? -cc_cr[i] : cc_cr[i];
      if (!(cp > 0)) begin
        all_pos = 1'b0;
      end
    end
    inside_load = all_pos;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_vld[0] <= 1'b0;
    end else if (en) begin
      sq_vld[0] <= vld_c;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq[0] <= sq_load;
      sq_inside[0] <= inside_load;
    end
  end

  for (genvar k = 0; k < R; k++) begin : g_sq
    always_ff @(posedge clk) begin
      if (rst) begin
        sq_vld[k+1] <= 1'b0;
      end else if (en) begin
        sq_vld[k+1] <= sq_vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int i = 0; i < 3; i++) begin
          sq[k+1][i] <= sq_step(sq[k][i]);
        end
        sq_inside[k+1] <= sq_inside[k];
      end
    end
  end

  // divider pipeline, one quotient bit per stage
  dv_t  dv_in [3];
  dv_t  dv [1:NQ][3];
  logic dv_vld [1:NQ];
  logic dv_inside [1:NQ];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dv_in[i].rem = '0;
      dv_in[i].root = sq[R][i].root;
      dv_in[i].q = sq[R][i].mag;
      dv_in[i].interior = sq[R][i].interior;
    end
  end

  for (genvar k = 1; k <= NQ; k++) begin : g_dv
    if (k == 1) begin : g_first
      always_ff @(posedge clk) begin
        if (rst) begin
          dv_vld[k] <= 1'b0;
        end else if (en) begin
          dv_vld[k] <= sq_vld[R];
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          for (int i = 0; i < 3; i++) begin
            dv[k][i] <= dv_step(dv_in[i]);
          end
          dv_inside[k] <= sq_inside[R];
        end
      end
    end else begin : g_rest
      always_ff @(posedge clk) begin
        if (rst) begin
          dv_vld[k] <= 1'b0;
        end else if (en) begin
          dv_vld[k] <= dv_vld[k-1];
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          for (int i = 0; i < 3; i++) begin
            dv[k][i] <= dv_step(dv[k-1][i]);
          end
          dv_inside[k] <= dv_inside[k-1];
        end
      end
    end
  end

  // stage E: nearest edge and sign
  logic                 vld_e;
  logic signed [DW-1:0] ee_d;
  logic [NQ-1:0]        dmin;

  always_comb begin
    logic [NQ-1:0] di;
    dmin = '1;
    for (int i = 0; i < 3; i++) begin
      di = dv[NQ][i].interior ? dv[NQ][i].q : NQ'(dv[NQ][i].root);
      if (di < dmin) begin
        dmin = di;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_e <= 1'b0;
    end else if (en) begin
      vld_e <= dv_vld[NQ];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ee_d <= dv_inside[NQ] ? -$signed({1'b0, dmin}) : $signed({1'b0, dmin});
    end
  end

  // stage F: coverage and blend factor
  logic                 vld_f;
  logic [F:0]           ff_a;
  logic [F:0]           ff_t;
  logic signed [KW-1:0] hs;
  logic signed [KW-1:0] ds;

  assign hs = $signed({{(KW-SB){1'b0}}, stroke_hw});
  assign ds = {{2{ee_d[DW-1]}}, ee_d};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_f <= 1'b0;
    end else if (en) begin
      vld_f <= vld_e;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ff_a <= clamp_unit(hs - ds + HALF_K);
      ff_t <= clamp_unit(HALF_K - hs - ds);
    end
  end

  // stage G: mix products
  logic                  vld_g;
  logic [F:0]            gg_a;
  logic [AW-1:0]         gg_a255;
  logic [CB-1:0]         gg_o [3];
  logic signed [PRW-1:0] gg_pr [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_g <= 1'b0;
    end else if (en) begin
      vld_g <= vld_f;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        gg_o[c] <= colour_pair[47 - CB*c -: CB];
        gg_pr[c] <= ($signed({1'b0, colour_pair[23 - CB*c -: CB]})
                     - $signed({1'b0, colour_pair[47 - CB*c -: CB]}))
                    * $signed({1'b0, ff_t});
      end
      gg_a <= ff_a;
      gg_a255 <= AW'(ff_a) * AW'(255);
    end
  end

  // stage H: premultiply
  logic                 vld_h;
  logic signed [MW-1:0] hh_m [3];
  logic [CB-1:0]        hh_alpha;
  logic                 hh_cov;
  logic signed [NW-1:0] hn [3];
  logic [AW-1:0]        a_round;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      hn[c] = $signed({1'b0, gg_o[c], {F{1'b0}}}) + NW'(gg_pr[c]);
    end
  end

  assign a_round = gg_a255 + ROUND_A;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_h <= 1'b0;
    end else if (en) begin
      vld_h <= vld_g;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        hh_m[c] <= hn[c] * $signed({1'b0, gg_a});
      end
      hh_alpha <= a_round[F +: CB];
      hh_cov <= gg_a != '0;
    end
  end

  // output word
  logic [MW-1:0] ch_round [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      ch_round[c] = MW'(hh_m[c]) + ROUND_M;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (en) begin
      result_valid <= vld_h;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result.pixel_argb <= {hh_alpha, ch_round[0][2*F +: CB], ch_round[1][2*F +: CB],
                            ch_round[2][2*F +: CB]};
      result.covered <= hh_cov;
    end
  end

  a_blend_bounded: assert property (@(posedge clk) disable iff (rst)
    vld_f |-> ff_t <= ff_a)
    else $error("blend factor above coverage");

  a_divisor_nonzero: assert property (@(posedge clk) disable iff (rst)
    sq_vld[R] && dv_in[0].interior |-> dv_in[0].root != '0)
    else $error("zero divisor on interior edge");

  a_uncovered_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.covered |-> result.pixel_argb == '0)
    else $error("uncovered pixel with colour");

endmodule
`default_nettype wire
